// File: hdl/rqr_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the request queue with retry.
package rqr_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ANSWER = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED = 3'd0,
      KIND_REFUSED  = 3'd1,
      KIND_SEND     = 3'd2,
      KIND_ANSWERED = 3'd3,
      KIND_RETRY    = 3'd4,
      KIND_GIVEN_UP = 3'd5
   } kind_type;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RETRY_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANSWER_TIMEOUT = 2'd1;

   localparam logic [7:0]  RETRY_COUNT_RESET    = 8'd3;
   localparam logic [15:0] ANSWER_TIMEOUT_RESET = 16'd100;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       last_byte;
      logic       transit;
      logic [3:0] offset;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       last;
      logic       entry_transit;
      logic [3:0] queue_count;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  length;
      logic [7:0]  retries;
      logic [15:0] timeout;
      logic        transit;
   } meta_type;

   typedef struct packed {
      logic [7:0]  retry_count;
      logic [15:0] answer_timeout;
   } cfg_type;

endpackage

// File: hdl/request_queue_with_retry_top.sv
`timescale 1ns / 1ps
// Top level of the request queue with retry.
//
// req_ channel: one word per command (request byte, answer seen, 1 ms tick).
// rsp_ channel: result words (accepted, refused, send byte, answered, retry,
// given up), each with the queue count after the step.
// csr_ channel: index 0 retry budget, index 1 answer timeout; always ready.
// A two-word buffer separates the front end from the executing back end.
// A request byte or answer is handled in ST_IDLE; a final byte gives its result
// word through the output register. A tick passes through ST_META (for the entry
// metadata read at the head), then a send run gives one byte per cycle while the
// output is not stalled, paced by the registered read of the packet byte memory.
// At most one item is in the back end; the front still takes up to two words.
// When rsp_ready is low while a word is valid, the output register holds and the back end waits.
// Reset empties the queue and restores the register defaults; packet
// storage is not cleared and needs no clearing pass.
module request_queue_with_retry_top import rqr_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_LEN     = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_last_byte,
   input  logic                       req_transit,
   input  logic [3:0]                 req_offset,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [2:0]                 rsp_kind,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last,
   output logic                       rsp_entry_transit,
   output logic [3:0]                 rsp_queue_count,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   item_type req_item, item;
   logic     item_valid, item_pop;
   rsp_type  rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RETRY_COUNT:    cfg_in.retry_count    = csr_wdata[7:0];
            CSR_ANSWER_TIMEOUT: cfg_in.answer_timeout = csr_wdata;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_count    <= RETRY_COUNT_RESET;
         cfg_ff.answer_timeout <= ANSWER_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item = '{cmd: cmd_type'(req_cmd), data_byte: req_data_byte,
                       last_byte: req_last_byte, transit: req_transit,
                       offset: req_offset};

   rqr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   rqr_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_LEN(MAX_LEN)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .cfg        (cfg_ff),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp),
      .rsp_ready  (rsp_ready)
   );

   assign rsp_kind          = rsp.kind;
   assign rsp_out_byte      = rsp.out_byte;
   assign rsp_last          = rsp.last;
   assign rsp_entry_transit = rsp.entry_transit;
   assign rsp_queue_count   = rsp.queue_count;

endmodule

// File: hdl/rqr_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with registered read.
module rqr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rqr_front.sv
`timescale 1ns / 1ps
// Front end: takes request words, drops unused commands, buffers two items.
module rqr_front import rqr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  item_type   req_item,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready && (req_item.cmd != CMD_NONE);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// File: hdl/rqr_back.sv
`timescale 1ns / 1ps
// Back end: queue state, packet stores, send runs, timeout and retry handling.
module rqr_back import rqr_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_LEN     = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   input  cfg_type  cfg,
   output logic     rsp_valid,
   output rsp_type  rsp,
   input  logic     rsp_ready
);

   localparam int SW = $clog2(QUEUE_DEPTH);
   localparam int CW = ((SW > 5) ? SW : 5) + 1;
   localparam int BD = QUEUE_DEPTH * MAX_LEN;
   localparam int BW = $clog2(BD);
   localparam logic [CW-1:0] QD_C = CW'(QUEUE_DEPTH);
   localparam logic [6:0]    ML_C = 7'(MAX_LEN);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_META = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [SW-1:0] head_ff, head_in, tail_ff, tail_in, slot_ff, slot_in;
   logic        waiting_ff, waiting_in, answer_ff, answer_in;
   logic [15:0] timer_ff, timer_in;
   logic [6:0]  ptr_ff, ptr_in, cnt_ff, cnt_in;
   logic        refused_ff, refused_in, append_ff, append_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic          byte_wr_en;
   logic [BW-1:0] byte_wr_addr, byte_rd_addr;
   logic [7:0]    byte_rd_data;
   logic          meta_wr_en;
   logic [SW-1:0] meta_wr_addr;
   meta_type      meta_wr_data, meta_rd;
   logic [$bits(meta_type)-1:0] meta_rd_data;

   logic [CW-1:0] diff, qlen, ofs_sum;
   logic [SW-1:0] head_inc, tail_inc, sel_slot;
   logic          sel_refused, sel_append, out_free;
   logic [6:0]    ptr_next;
   logic [15:0]   t;
   logic [7:0]    r;

   assign meta_rd = meta_type'(meta_rd_data);

   always_comb begin
      diff = CW'(tail_ff) + QD_C - CW'(head_ff);
      qlen = (diff >= QD_C) ? diff - QD_C : diff;
      head_inc = ((CW'(head_ff) + CW'(1)) == QD_C) ? '0 : head_ff + SW'(1);
      tail_inc = ((CW'(tail_ff) + CW'(1)) == QD_C) ? '0 : tail_ff + SW'(1);
      ofs_sum = CW'(head_ff) + CW'(item.offset);
      if (ofs_sum >= QD_C) begin
         ofs_sum = ofs_sum - QD_C;
      end
      out_free = !rsp_valid_ff || rsp_ready;

      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      slot_in      = slot_ff;
      waiting_in   = waiting_ff;
      answer_in    = answer_ff;
      timer_in     = timer_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      refused_in   = refused_ff;
      append_in    = append_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      item_pop     = 1'b0;
      byte_wr_en   = 1'b0;
      meta_wr_en   = 1'b0;
      meta_wr_addr = head_ff;
      meta_wr_data = meta_rd;
      sel_slot     = slot_ff;
      sel_refused  = refused_ff;
      sel_append   = append_ff;
      ptr_next     = ptr_ff;
      t            = timer_ff;
      r            = meta_rd.retries;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && out_free) begin
               item_pop = 1'b1;
               unique case (item.cmd)
                  CMD_LOAD: begin
                     if (ptr_ff == 7'd0) begin
                        sel_refused = 1'b0;
                        sel_append  = 1'b1;
                        if ((item.offset != 4'd0) &&
                            (qlen >= CW'(item.offset) + CW'(1))) begin
                           sel_slot   = ofs_sum[SW-1:0];
                           sel_append = 1'b0;
                        end else if (qlen < QD_C - CW'(1)) begin
                           sel_slot = tail_ff;
                        end else begin
                           sel_refused = 1'b1;
                           sel_slot    = '0;
                        end
                     end
                     if (ptr_ff < ML_C) begin
                        byte_wr_en = !sel_refused;
                        ptr_next   = ptr_ff + 7'd1;
                     end
                     slot_in    = sel_slot;
                     refused_in = sel_refused;
                     append_in  = sel_append;
                     ptr_in     = ptr_next;
                     if (item.last_byte) begin
                        ptr_in       = 7'd0;
                        refused_in   = 1'b0;
                        rsp_valid_in = 1'b1;
                        rsp_in       = '0;
                        rsp_in.last  = 1'b1;
                        if (sel_refused) begin
                           rsp_in.kind        = KIND_REFUSED;
                           rsp_in.queue_count = 4'(qlen);
                        end else begin
                           meta_wr_en   = 1'b1;
                           meta_wr_addr = sel_slot;
                           meta_wr_data = {ptr_next, cfg.retry_count,
                                           cfg.answer_timeout, item.transit};
                           if (sel_append) begin
                              tail_in = tail_inc;
                           end
                           rsp_in.kind        = KIND_ACCEPTED;
                           rsp_in.queue_count = 4'(qlen + CW'(sel_append));
                        end
                     end
                  end
                  CMD_ANSWER: answer_in = 1'b1;
                  CMD_TICK:   state_in = ST_META;
                  default:    ;
               endcase
            end
         end
         ST_META: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (!waiting_ff) begin
                  if (qlen != '0) begin
                     timer_in   = meta_rd.timeout;
                     answer_in  = 1'b0;
                     waiting_in = 1'b1;
                     cnt_in     = 7'd0;
                     if (meta_rd.length != 7'd0) begin
                        state_in = ST_SEND;
                     end
                  end
               end else if (answer_ff) begin
                  answer_in    = 1'b0;
                  head_in      = head_inc;
                  waiting_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.kind  = KIND_ANSWERED;
                  rsp_in.last  = 1'b1;
                  rsp_in.entry_transit = meta_rd.transit;
                  rsp_in.queue_count   = 4'(qlen - CW'(1));
               end else begin
                  if (t != 16'd0) begin
                     t = t - 16'd1;
                  end
                  timer_in = t;
                  if (t == 16'd0) begin
                     waiting_in = 1'b0;
                     if (r != 8'd0) begin
                        r = r - 8'd1;
                     end
                     meta_wr_en           = 1'b1;
                     meta_wr_data.retries = r;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                     rsp_in.last  = 1'b1;
                     rsp_in.entry_transit = meta_rd.transit;
                     if (r == 8'd0) begin
                        head_in            = head_inc;
                        rsp_in.kind        = KIND_GIVEN_UP;
                        rsp_in.queue_count = 4'(qlen - CW'(1));
                     end else begin
                        rsp_in.kind        = KIND_RETRY;
                        rsp_in.queue_count = 4'(qlen);
                     end
                  end
               end
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = KIND_SEND;
               rsp_in.out_byte      = byte_rd_data;
               rsp_in.entry_transit = meta_rd.transit;
               rsp_in.queue_count   = 4'(qlen);
               rsp_in.last          = (cnt_ff + 7'd1 == meta_rd.length);
               if (rsp_in.last) begin
                  cnt_in   = 7'd0;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      byte_wr_addr = BW'(sel_slot) * BW'(MAX_LEN) + BW'(ptr_ff);
      byte_rd_addr = BW'(head_ff) * BW'(MAX_LEN) + BW'(cnt_in);
   end

   rqr_ram #(.WIDTH(8), .DEPTH(BD)) u_bytes (
      .clock   (clock),
      .wr_en   (byte_wr_en),
      .wr_addr (byte_wr_addr),
      .wr_data (item.data_byte),
      .rd_addr (byte_rd_addr),
      .rd_data (byte_rd_data)
   );

   rqr_ram #(.WIDTH($bits(meta_type)), .DEPTH(QUEUE_DEPTH)) u_meta (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_addr (head_ff),
      .rd_data (meta_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         slot_ff      <= '0;
         waiting_ff   <= 1'b0;
         answer_ff    <= 1'b0;
         timer_ff     <= 16'd0;
         ptr_ff       <= 7'd0;
         cnt_ff       <= 7'd0;
         refused_ff   <= 1'b0;
         append_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         slot_ff      <= slot_in;
         waiting_ff   <= waiting_in;
         answer_ff    <= answer_in;
         timer_ff     <= timer_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         refused_ff   <= refused_in;
         append_ff    <= append_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: test/tb_request_queue_with_retry_top.sv
`timescale 1ns / 1ps
// Testbench of the request queue with retry: directed table, a fill to the refusal point, then random words.
module tb_request_queue_with_retry_top;
   import rqr_pkg::*;

   localparam int DEPTH = 16;
   localparam int MAXLEN = 64;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      item_type it;
      bit       fixed;
      kind_type kind;
      logic     tr;
      logic [3:0] qc;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_cmd = '0;
   logic [7:0] req_data_byte = '0;
   logic req_last_byte = 0;
   logic req_transit = 0;
   logic [3:0] req_offset = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic rsp_last;
   logic rsp_entry_transit;
   logic [3:0] rsp_queue_count;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   request_queue_with_retry_top dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // queue model
   logic [7:0]  pkt_bytes [DEPTH][MAXLEN];
   logic [6:0]  pkt_len [DEPTH];
   logic [7:0]  pkt_retries [DEPTH];
   logic [15:0] pkt_timeout [DEPTH];
   logic        pkt_transit [DEPTH];
   logic [3:0]  head, tail, fill_slot;
   logic        busy_wait, answered, fill_refused, fill_append;
   logic [15:0] timer;
   int          fill_ptr;
   logic [7:0]  cfg_retries = RETRY_COUNT_RESET;
   logic [15:0] cfg_timeout = ANSWER_TIMEOUT_RESET;

   rsp_type step_words[$];
   rsp_type expected_words[$];
   row_type rows[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 0;

   function automatic logic [3:0] depth_used();
      return tail - head;
   endfunction

   function automatic void emit(kind_type k, logic [7:0] b, logic l, logic tr);
      rsp_type w;
      w.kind = k;
      w.out_byte = b;
      w.last = l;
      w.entry_transit = tr;
      w.queue_count = depth_used();
      step_words.push_back(w);
   endfunction

   function automatic void predict_word(item_type it);
      int n, len;
      logic [3:0] h;
      step_words.delete();
      case (it.cmd)
         CMD_LOAD: begin
            if (fill_ptr == 0) begin
               n = depth_used();
               fill_refused = 0;
               fill_append = 1;
               if (it.offset != 0 && n >= it.offset + 1) begin
                  fill_slot = head + it.offset;
                  fill_append = 0;
               end else if (n < DEPTH - 1) begin
                  fill_slot = tail;
               end else begin
                  fill_refused = 1;
                  fill_slot = 0;
               end
            end
            if (fill_ptr < MAXLEN) begin
               if (!fill_refused) pkt_bytes[fill_slot][fill_ptr] = it.data_byte;
               fill_ptr++;
            end
            if (it.last_byte) begin
               len = fill_ptr;
               fill_ptr = 0;
               if (fill_refused) begin
                  fill_refused = 0;
                  emit(KIND_REFUSED, 0, 1, 0);
               end else begin
                  pkt_len[fill_slot] = 7'(len);
                  pkt_retries[fill_slot] = cfg_retries;
                  pkt_timeout[fill_slot] = cfg_timeout;
                  pkt_transit[fill_slot] = it.transit;
                  if (fill_append) tail = tail + 1;
                  emit(KIND_ACCEPTED, 0, 1, 0);
               end
            end
         end
         CMD_ANSWER: answered = 1;
         CMD_TICK: begin
            h = head;
            if (!busy_wait) begin
               if (depth_used() != 0) begin
                  timer = pkt_timeout[h];
                  answered = 0;
                  busy_wait = 1;
                  for (int i = 0; i < pkt_len[h]; i++)
                     emit(KIND_SEND, pkt_bytes[h][i], i + 1 == pkt_len[h], pkt_transit[h]);
               end
            end else if (answered) begin
               answered = 0;
               head = head + 1;
               busy_wait = 0;
               emit(KIND_ANSWERED, 0, 1, pkt_transit[h]);
            end else begin
               if (timer != 0) timer--;
               if (timer == 0) begin
                  busy_wait = 0;
                  if (pkt_retries[h] != 0) pkt_retries[h]--;
                  if (pkt_retries[h] == 0) begin
                     head = head + 1;
                     emit(KIND_GIVEN_UP, 0, 1, pkt_transit[h]);
                  end else begin
                     emit(KIND_RETRY, 0, 1, pkt_transit[h]);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report("unexpected word kind", rsp_kind, -1);
         end else begin
            w = expected_words.pop_front();
            if (rsp_kind != w.kind) report("kind", rsp_kind, w.kind);
            if (rsp_out_byte != w.out_byte) report("out_byte", rsp_out_byte, w.out_byte);
            if (rsp_last != w.last) report("last", rsp_last, w.last);
            if (rsp_entry_transit != w.entry_transit)
               report("entry_transit", rsp_entry_transit, w.entry_transit);
            if (rsp_queue_count != w.queue_count)
               report("queue_count", rsp_queue_count, w.queue_count);
         end
      end
   end

   int stall = 0;
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1;
      end else if (stall > 0) begin
         stall <= stall - 1;
         rsp_ready <= 0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall <= $urandom_range(0, 10);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   task automatic push_word(row_type r);
      rsp_type w;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= r.it.cmd;
      req_data_byte <= r.it.data_byte;
      req_last_byte <= r.it.last_byte;
      req_transit <= r.it.transit;
      req_offset <= r.it.offset;
      do @(posedge clock); while (!req_ready);
      predict_word(r.it);
      if (r.fixed) begin
         w.kind = r.kind;
         w.out_byte = 0;
         w.last = 1;
         w.entry_transit = r.tr;
         w.queue_count = r.qc;
         expected_words.push_back(w);
      end else begin
         foreach (step_words[i]) expected_words.push_back(step_words[i]);
      end
   endtask

   function automatic row_type mk(cmd_type c, logic [7:0] d, logic l, logic tr,
                                  logic [3:0] ofs);
      row_type r;
      r.it.cmd = c;
      r.it.data_byte = d;
      r.it.last_byte = l;
      r.it.transit = tr;
      r.it.offset = ofs;
      r.fixed = 0;
      r.kind = KIND_ACCEPTED;
      r.tr = 0;
      r.qc = 0;
      return r;
   endfunction

   function automatic row_type fx(row_type r, kind_type k, logic tr, logic [3:0] qc);
      r.fixed = 1;
      r.kind = k;
      r.tr = tr;
      r.qc = qc;
      return r;
   endfunction

   task automatic go(cmd_type c, int d, int l, int tr, int ofs);
      push_word(mk(c, 8'(d), 1'(l), 1'(tr), 4'(ofs)));
   endtask

   task automatic settle();
      req_valid <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_RETRY_COUNT) cfg_retries = val[7:0];
      else cfg_timeout = val;
   endtask

   task automatic drain();
      if (fill_ptr != 0) go(CMD_LOAD, $urandom, 1, $urandom, 0);
      while (depth_used() != 0 || busy_wait) begin
         if (busy_wait) go(CMD_ANSWER, $urandom, $urandom, $urandom, $urandom);
         go(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic random_words(int target);
      int done, len, r;
      logic [3:0] ofs;
      done = 0;
      while (done < target) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 5);
            ofs = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
            for (int i = 0; i < len; i++) begin
               go(CMD_LOAD, $urandom, int'(i == len - 1), $urandom,
                  (i == 0) ? int'(ofs) : int'($urandom));
               if ($urandom_range(0, 19) == 0) go(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
            end
            done += len;
         end else if (r < 80) begin
            go(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
            done++;
         end else if (r < 92) begin
            go(CMD_ANSWER, $urandom, $urandom, $urandom, $urandom);
            done++;
         end else begin
            go(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      head = 0;
      tail = 0;
      busy_wait = 0;
      answered = 0;
      timer = 0;
      fill_slot = 0;
      fill_ptr = 0;
      fill_refused = 0;
      fill_append = 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      rows.push_back(mk(CMD_TICK, 8'h00, 0, 0, 0));
      rows.push_back(fx(mk(CMD_LOAD, 8'h00, 1, 0, 0), KIND_ACCEPTED, 0, 1));
      rows.push_back(mk(CMD_LOAD, 8'hFF, 0, 1, 0));
      rows.push_back(fx(mk(CMD_LOAD, 8'hA5, 1, 1, 15), KIND_ACCEPTED, 0, 2));
      rows.push_back(mk(CMD_NONE, 8'hFF, 1, 1, 15));
      rows.push_back(mk(CMD_ANSWER, 8'h00, 0, 0, 0));
      rows.push_back(mk(CMD_TICK, 8'h00, 0, 0, 0));
      rows.push_back(mk(CMD_TICK, 8'hFF, 1, 1, 15));
      rows.push_back(mk(CMD_ANSWER, 8'hFF, 1, 1, 15));
      rows.push_back(fx(mk(CMD_TICK, 8'h00, 0, 0, 0), KIND_ANSWERED, 0, 1));
      rows.push_back(mk(CMD_TICK, 8'h00, 0, 0, 0));
      rows.push_back(fx(mk(CMD_LOAD, 8'h5A, 1, 0, 15), KIND_ACCEPTED, 0, 2));
      rows.push_back(fx(mk(CMD_LOAD, 8'h11, 1, 1, 1), KIND_ACCEPTED, 0, 2));
      rows.push_back(mk(CMD_ANSWER, 8'h00, 0, 0, 0));
      rows.push_back(fx(mk(CMD_TICK, 8'h00, 0, 0, 0), KIND_ANSWERED, 1, 1));
      foreach (rows[i]) push_word(rows[i]);

      // fill up to the refusal point
      for (int i = 0; i < 16; i++) go(CMD_LOAD, $urandom, 1, $urandom, 0);
      drain();
      settle();

      write_csr(CSR_RETRY_COUNT, 16'd0);
      write_csr(CSR_ANSWER_TIMEOUT, 16'd0);
      random_words(65);
      drain();
      settle();

      write_csr(CSR_RETRY_COUNT, 16'd2);
      write_csr(CSR_ANSWER_TIMEOUT, 16'd3);
      random_words(65);
      drain();
      settle();

      write_csr(CSR_RETRY_COUNT, 16'd255);
      write_csr(CSR_ANSWER_TIMEOUT, 16'hFFFF);
      random_words(55);
      drain();
      settle();

      write_csr(CSR_RETRY_COUNT, 16'd1);
      write_csr(CSR_ANSWER_TIMEOUT, 16'd1);
      quiet = 1;
      random_words(55);
      drain();
      settle();

      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
